>>> rtl/core/lbm_pkg.sv
package lbm_pkg;

    // Fixed point format and field widths
    localparam int FB   = 28;          // fraction bits
    localparam int DW   = 32;          // distribution width
    localparam int NDIR = 9;           // lattice directions
    localparam int RW   = FB + 1;      // relaxation rate width
    localparam int SW   = DW + 4;      // sum of nine distributions
    localparam int DVW  = FB + 2;      // divider remainder and denominator
    localparam int QW   = FB + 1;      // quotient magnitude, up to 2^FB
    localparam int UW   = QW + 1;      // signed velocity
    localparam int RHOW = 31;          // reported density

    localparam logic [RW-1:0] RELAX_RESET = RW'(394758024);

    // Q constants, rounded to nearest
    localparam longint Q_ONE      = longint'(1) << FB;
    localparam longint Q_HALF     = Q_ONE / 2;
    localparam longint Q_RHO_MAX  = 3 * Q_ONE / 2;
    localparam longint SPEED2_MAX = (4 * Q_ONE + 50) / 100;
    localparam longint W_REST     = (4 * Q_ONE + 4) / 9;
    localparam longint W_AXIS     = (Q_ONE + 4) / 9;
    localparam longint W_DIAG     = (Q_ONE + 18) / 36;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_UNSTABLE = 2'd1,
        STAT_SKIP     = 2'd2
    } status_t;

    // Per-cell data that rides along the pipeline
    typedef struct packed {
        logic [NDIR-1:0][DW-1:0] f;
        logic [7:0]              blocked;
        logic                    solid;
        logic                    ok;
        logic [RHOW-1:0]         density;
    } side_t;

endpackage

>>> rtl/core/lbm_d2q9_bgk_cell_update.sv
// Channel  | Signals                          | Contents
// ---------+----------------------------------+---------------------------------
// s        | s_tvalid s_tready s_tdata s_tuser| nine distributions, blocked mask
// m        | m_tvalid m_tready m_tdata m_tuser| nine post values, mask, density
// cfg      | cfg_valid cfg_ready cfg_data     | relaxation rate omega
//
// One cell is accepted per cycle while the output is not stalled; the restoring
// divider gives one quotient bit per stage for 29 stages.
// rst_n clears the valid bits and loads the reset relaxation rate.
// The whole pipeline holds while a result waits at m with m_tready low;
// s_tready drops only then, and no transaction is lost or repeated.
module lbm_d2q9_bgk_cell_update (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [295:0]            s_tdata,   // pre_0..pre_8, blocked_dirs
    input  logic [0:0]              s_tuser,   // cell_solid
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [327:0]            m_tdata,   // post_0..post_8, reflect_mask, density, pad
    output logic [1:0]              m_tuser,   // status
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [lbm_pkg::RW-1:0]  cfg_data
);
    import lbm_pkg::*;

    localparam int CW    = UW + 1;             // u+v, u-v
    localparam int SQW   = 2 * CW;
    localparam int RQW   = SQW - FB + 1;       // rounded square
    localparam int PW    = RQW + 8;            // polynomial
    localparam int PMW   = FB + 3;             // polynomial magnitude into multiply
    localparam int FMW   = RHOW + PMW + 1 - FB;
    localparam int FEQW  = FMW + 1;
    localparam int DMW   = FEQW + 1;
    localparam int GPW   = RW + DMW;
    localparam int HRW   = GPW + 1 - FB;
    localparam int POSTW = HRW + 2;

    localparam logic [SQW:0]        RND_SQ  = (SQW+1)'(Q_HALF);
    localparam logic [FB+RHOW:0]    RND_WR  = (FB+RHOW+1)'(Q_HALF);
    localparam logic [RHOW+PMW:0]   RND_FQ  = (RHOW+PMW+1)'(Q_HALF);
    localparam logic [GPW:0]        RND_G   = (GPW+1)'(Q_HALF);

    logic en;
    logic [RW-1:0] relax_rate_reg;

    // Stage registers
    logic                   a_valid_reg;
    side_t                  a_side_reg;
    logic signed [SW-1:0]   a_rho_reg, a_mx_reg, a_my_reg;

    logic                   dv_valid;
    logic signed [UW-1:0]   dv_u, dv_v;
    side_t                  dv_side;

    logic                   c_valid_reg;
    side_t                  c_side_reg;
    logic signed [UW-1:0]   c_u_reg, c_v_reg;

    logic                   d_valid_reg;
    side_t                  d_side_reg;
    logic signed [UW-1:0]   d_u_reg, d_v_reg;
    logic [RQW-1:0]         d_sq_reg [4];
    logic [RHOW-1:0]        d_wr_reg [3];

    logic                   e_valid_reg;
    side_t                  e_side_reg;
    logic signed [PW-1:0]   e_poly_reg [NDIR];
    logic [RHOW-1:0]        e_wr_reg [3];

    logic                   f_valid_reg;
    side_t                  f_side_reg;
    logic signed [FEQW-1:0] f_feq_reg [NDIR];

    logic                   g_valid_reg;
    side_t                  g_side_reg;
    logic [GPW-1:0]         g_prod_reg [NDIR];
    logic                   g_neg_reg [NDIR];

    logic                   h_valid_reg;
    logic [327:0]           m_tdata_reg;
    logic [1:0]             m_tuser_reg;

    // Global advance: hold everything while the output waits
    assign en        = !h_valid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = h_valid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // Take relaxation rate writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relax_rate_reg <= RELAX_RESET;
        end
        else if (cfg_valid)
        begin
            relax_rate_reg <= cfg_data;
        end
    end

    // Valid bits for the stages outside the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= s_tvalid;
            c_valid_reg <= dv_valid;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= f_valid_reg;
            h_valid_reg <= g_valid_reg;
        end
    end

    // Stage A: density and momentum sums
    logic signed [DW-1:0] pre [NDIR];
    logic signed [SW-1:0] rho_a, mx_a, my_a;
    side_t                side_a;

    always_comb
    begin
        rho_a  = '0;
        side_a = '0;
        for (int k = 0; k < NDIR; k++)
        begin
            pre[k]      = $signed(s_tdata[k*DW +: DW]);
            side_a.f[k] = s_tdata[k*DW +: DW];
            rho_a       = rho_a + SW'(pre[k]);
        end
        side_a.blocked = s_tdata[NDIR*DW +: 8];
        side_a.solid   = s_tuser[0];
        mx_a = SW'(pre[1]) + SW'(pre[5]) + SW'(pre[8])
             - SW'(pre[3]) - SW'(pre[6]) - SW'(pre[7]);
        my_a = SW'(pre[2]) + SW'(pre[5]) + SW'(pre[6])
             - SW'(pre[4]) - SW'(pre[7]) - SW'(pre[8]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side_reg <= side_a;
            a_rho_reg  <= rho_a;
            a_mx_reg   <= mx_a;
            a_my_reg   <= my_a;
        end
    end

    // Stage B: range checks, clamp density, feed the divider
    logic [SW-1:0]  mx_mag, my_mag;
    logic           ok_b;
    side_t          side_b;
    logic [DVW-1:0] num_u_b, num_v_b, den_b;

    always_comb
    begin
        mx_mag = a_mx_reg[SW-1] ? SW'(-a_mx_reg) : SW'(a_mx_reg);
        my_mag = a_my_reg[SW-1] ? SW'(-a_my_reg) : SW'(a_my_reg);
        ok_b = (a_rho_reg >= $signed(SW'(Q_HALF))) && (a_rho_reg <= $signed(SW'(Q_RHO_MAX)))
            && (mx_mag <= SW'(a_rho_reg)) && (my_mag <= SW'(a_rho_reg));
        side_b    = a_side_reg;
        side_b.ok = ok_b;
        if (a_rho_reg[SW-1])
        begin
            side_b.density = '0;
        end
        else if (a_rho_reg > $signed({{(SW-RHOW){1'b0}}, {RHOW{1'b1}}}))
        begin
            side_b.density = '1;
        end
        else
        begin
            side_b.density = a_rho_reg[RHOW-1:0];
        end
        num_u_b = ok_b ? mx_mag[DVW-1:0] : '0;
        num_v_b = ok_b ? my_mag[DVW-1:0] : '0;
        den_b   = ok_b ? a_rho_reg[DVW-1:0] : DVW'(Q_ONE);
    end

    lbm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (a_valid_reg),
        .in_num_u (num_u_b),
        .in_num_v (num_v_b),
        .in_neg_u (a_mx_reg[SW-1]),
        .in_neg_v (a_my_reg[SW-1]),
        .in_den   (den_b),
        .in_side  (side_b),
        .out_valid(dv_valid),
        .out_u    (dv_u),
        .out_v    (dv_v),
        .out_side (dv_side)
    );

    // Stage C: capture velocity
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_side_reg <= dv_side;
            c_u_reg    <= dv_u;
            c_v_reg    <= dv_v;
        end
    end

    // Stage D: rounded squares and weighted densities
    logic signed [CW-1:0] s_d, t_d;
    logic [CW-1:0]        mag_d [4];
    logic [SQW:0]         sq_full [4];
    logic [RQW-1:0]       sq_d [4];
    logic [FB+RHOW:0]     wr_full [3];
    logic [RHOW-1:0]      wr_d [3];
    logic [FB-1:0]        wconst [3];

    always_comb
    begin
        s_d = CW'(c_u_reg) + CW'(c_v_reg);
        t_d = CW'(c_u_reg) - CW'(c_v_reg);
        mag_d[0] = c_u_reg[UW-1] ? CW'(-CW'(c_u_reg)) : CW'(c_u_reg);
        mag_d[1] = c_v_reg[UW-1] ? CW'(-CW'(c_v_reg)) : CW'(c_v_reg);
        mag_d[2] = s_d[CW-1] ? CW'(-s_d) : CW'(s_d);
        mag_d[3] = t_d[CW-1] ? CW'(-t_d) : CW'(t_d);
        for (int i = 0; i < 4; i++)
        begin
            sq_full[i] = (SQW+1)'(mag_d[i]) * (SQW+1)'(mag_d[i]) + RND_SQ;
            sq_d[i]    = RQW'(sq_full[i] >> FB);
        end
        wconst[0] = FB'(W_REST);
        wconst[1] = FB'(W_AXIS);
        wconst[2] = FB'(W_DIAG);
        for (int i = 0; i < 3; i++)
        begin
            wr_full[i] = (FB+RHOW+1)'(wconst[i]) * (FB+RHOW+1)'(c_side_reg.density)
                       + RND_WR;
            wr_d[i]    = RHOW'(wr_full[i] >> FB);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_side_reg <= c_side_reg;
            d_u_reg    <= c_u_reg;
            d_v_reg    <= c_v_reg;
            for (int i = 0; i < 4; i++)
            begin
                d_sq_reg[i] <= sq_d[i];
            end
            for (int i = 0; i < 3; i++)
            begin
                d_wr_reg[i] <= wr_d[i];
            end
        end
    end

    // Stage E: speed limit and equilibrium polynomial per direction
    logic [RQW:0]         usq_e;
    logic [RQW+2:0]       t15_e;
    logic signed [CW-1:0] uu_e, vv_e, su_e, df_e;
    logic signed [CW-1:0] cu_e [NDIR];
    logic [RQW-1:0]       cu2_e [NDIR];
    logic [RQW+3:0]       t45_e [NDIR];
    logic signed [PW-1:0] poly_e [NDIR];
    side_t                side_e;

    always_comb
    begin
        usq_e = (RQW+1)'(d_sq_reg[0]) + (RQW+1)'(d_sq_reg[1]);
        t15_e = ((RQW+3)'(usq_e) * (RQW+3)'(3) + (RQW+3)'(1)) >> 1;
        side_e    = d_side_reg;
        side_e.ok = d_side_reg.ok && (usq_e <= (RQW+1)'(SPEED2_MAX));
        uu_e = CW'(d_u_reg);
        vv_e = CW'(d_v_reg);
        su_e = uu_e + vv_e;
        df_e = uu_e - vv_e;
        cu_e[0] = '0;    cu2_e[0] = '0;
        cu_e[1] = uu_e;  cu2_e[1] = d_sq_reg[0];
        cu_e[2] = vv_e;  cu2_e[2] = d_sq_reg[1];
        cu_e[3] = -uu_e; cu2_e[3] = d_sq_reg[0];
        cu_e[4] = -vv_e; cu2_e[4] = d_sq_reg[1];
        cu_e[5] = su_e;  cu2_e[5] = d_sq_reg[2];
        cu_e[6] = -df_e; cu2_e[6] = d_sq_reg[3];
        cu_e[7] = -su_e; cu2_e[7] = d_sq_reg[2];
        cu_e[8] = df_e;  cu2_e[8] = d_sq_reg[3];
        for (int k = 0; k < NDIR; k++)
        begin
            t45_e[k]  = ((RQW+4)'(cu2_e[k]) * (RQW+4)'(9) + (RQW+4)'(1)) >> 1;
            poly_e[k] = PW'(Q_ONE) + PW'(cu_e[k]) * PW'(3)
                      + $signed(PW'(t45_e[k])) - $signed(PW'(t15_e));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_side_reg <= side_e;
            for (int k = 0; k < NDIR; k++)
            begin
                e_poly_reg[k] <= poly_e[k];
            end
            for (int i = 0; i < 3; i++)
            begin
                e_wr_reg[i] <= d_wr_reg[i];
            end
        end
    end

    // Stage F: equilibrium = weighted density times polynomial
    logic [PMW-1:0]        pmag_f [NDIR];
    logic [RHOW-1:0]       wsel_f [NDIR];
    logic [RHOW+PMW:0]     fq_full [NDIR];
    logic [FMW-1:0]        fq_mag [NDIR];
    logic signed [FEQW-1:0] feq_f [NDIR];

    always_comb
    begin
        for (int k = 0; k < NDIR; k++)
        begin
            if (k == 0)
            begin
                wsel_f[k] = e_wr_reg[0];
            end
            else if (k < 5)
            begin
                wsel_f[k] = e_wr_reg[1];
            end
            else
            begin
                wsel_f[k] = e_wr_reg[2];
            end
            pmag_f[k]  = e_poly_reg[k][PW-1] ? PMW'(-e_poly_reg[k]) : PMW'(e_poly_reg[k]);
            fq_full[k] = (RHOW+PMW+1)'(wsel_f[k]) * (RHOW+PMW+1)'(pmag_f[k]) + RND_FQ;
            fq_mag[k]  = FMW'(fq_full[k] >> FB);
            feq_f[k]   = e_poly_reg[k][PW-1] ? -$signed({1'b0, fq_mag[k]})
                                             :  $signed({1'b0, fq_mag[k]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_side_reg <= e_side_reg;
            for (int k = 0; k < NDIR; k++)
            begin
                f_feq_reg[k] <= feq_f[k];
            end
        end
    end

    // Stage G: omega times (feq - f), on magnitudes
    logic signed [DMW-1:0] diff_g [NDIR];
    logic [DMW-1:0]        dmag_g [NDIR];
    logic [GPW-1:0]        prod_g [NDIR];

    always_comb
    begin
        for (int k = 0; k < NDIR; k++)
        begin
            diff_g[k] = DMW'(f_feq_reg[k]) - DMW'($signed(f_side_reg.f[k]));
            dmag_g[k] = diff_g[k][DMW-1] ? DMW'(-diff_g[k]) : DMW'(diff_g[k]);
            prod_g[k] = GPW'(relax_rate_reg) * GPW'(dmag_g[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_side_reg <= f_side_reg;
            for (int k = 0; k < NDIR; k++)
            begin
                g_prod_reg[k] <= prod_g[k];
                g_neg_reg[k]  <= diff_g[k][DMW-1];
            end
        end
    end

    // Stage H: round, add back, saturate, select by status
    logic [GPW:0]           r_full [NDIR];
    logic [HRW-1:0]         r_mag [NDIR];
    logic signed [POSTW-1:0] post_h [NDIR];
    logic [DW-1:0]          sat_h [NDIR];
    logic [327:0]           m_tdata_next;
    logic [1:0]             m_tuser_next;

    always_comb
    begin
        for (int k = 0; k < NDIR; k++)
        begin
            r_full[k] = (GPW+1)'(g_prod_reg[k]) + RND_G;
            r_mag[k]  = HRW'(r_full[k] >> FB);
            post_h[k] = POSTW'($signed(g_side_reg.f[k]))
                      + (g_neg_reg[k] ? -$signed(POSTW'(r_mag[k])) : $signed(POSTW'(r_mag[k])));
            if (post_h[k] > $signed(POSTW'(32'h7FFF_FFFF)))
            begin
                sat_h[k] = 32'h7FFF_FFFF;
            end
            else if (post_h[k] < -$signed(POSTW'(33'h0_8000_0000)))
            begin
                sat_h[k] = 32'h8000_0000;
            end
            else
            begin
                sat_h[k] = post_h[k][DW-1:0];
            end
        end
        m_tdata_next = '0;
        if (g_side_reg.solid)
        begin
            m_tuser_next = STAT_SKIP;
        end
        else if (!g_side_reg.ok)
        begin
            m_tuser_next = STAT_UNSTABLE;
            m_tdata_next[NDIR*DW+8 +: RHOW] = g_side_reg.density;
        end
        else
        begin
            m_tuser_next = STAT_OK;
            for (int k = 0; k < NDIR; k++)
            begin
                m_tdata_next[k*DW +: DW] = sat_h[k];
            end
            m_tdata_next[NDIR*DW +: 8]      = g_side_reg.blocked;
            m_tdata_next[NDIR*DW+8 +: RHOW] = g_side_reg.density;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    // Checks
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STAT_SKIP) |-> (m_tdata == '0))
        else $error("skipped cell carries data");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != STAT_OK) |-> (m_tdata[NDIR*DW+7:0] == '0))
        else $error("non-ok cell carries post values or mask");

    a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output stall");

endmodule

>>> rtl/core/lbm_div.sv
module lbm_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [lbm_pkg::DVW-1:0]           in_num_u,
    input  logic [lbm_pkg::DVW-1:0]           in_num_v,
    input  logic                              in_neg_u,
    input  logic                              in_neg_v,
    input  logic [lbm_pkg::DVW-1:0]           in_den,
    input  lbm_pkg::side_t                    in_side,
    output logic                              out_valid,
    output logic signed [lbm_pkg::UW-1:0]     out_u,
    output logic signed [lbm_pkg::UW-1:0]     out_v,
    output lbm_pkg::side_t                    out_side
);
    import lbm_pkg::*;

    localparam int DS = QW;

    logic           valid_reg [DS];
    logic [DVW-1:0] rem_u_reg [DS];
    logic [DVW-1:0] rem_v_reg [DS];
    logic [QW-1:0]  q_u_reg   [DS];
    logic [QW-1:0]  q_v_reg   [DS];
    logic           neg_u_reg [DS];
    logic           neg_v_reg [DS];
    logic [DVW-1:0] den_reg   [DS];
    side_t          side_reg  [DS];

    // One quotient bit per stage, both axes share the denominator
    for (genvar j = 0; j < DS; j++) begin : g_step
        logic [DVW-1:0] ru;
        logic [DVW-1:0] rv;
        logic [DVW-1:0] dn;
        logic [QW-1:0]  qu;
        logic [QW-1:0]  qv;
        logic           nu;
        logic           nv;
        logic           vin;
        side_t          sd;
        logic           ge_u;
        logic           ge_v;
        logic [DVW-1:0] rem_u_next;
        logic [DVW-1:0] rem_v_next;
        logic [QW-1:0]  q_u_next;
        logic [QW-1:0]  q_v_next;

        if (j == 0) begin : g_first
            assign ru  = in_num_u;
            assign rv  = in_num_v;
            assign dn  = in_den;
            assign qu  = '0;
            assign qv  = '0;
            assign nu  = in_neg_u;
            assign nv  = in_neg_v;
            assign vin = in_valid;
            assign sd  = in_side;
        end
        else begin : g_rest
            assign ru  = {rem_u_reg[j-1][DVW-2:0], 1'b0};
            assign rv  = {rem_v_reg[j-1][DVW-2:0], 1'b0};
            assign dn  = den_reg[j-1];
            assign qu  = q_u_reg[j-1];
            assign qv  = q_v_reg[j-1];
            assign nu  = neg_u_reg[j-1];
            assign nv  = neg_v_reg[j-1];
            assign vin = valid_reg[j-1];
            assign sd  = side_reg[j-1];
        end

        always_comb
        begin
            ge_u       = (ru >= dn);
            ge_v       = (rv >= dn);
            rem_u_next = ge_u ? (ru - dn) : ru;
            rem_v_next = ge_v ? (rv - dn) : rv;
            q_u_next   = {qu[QW-2:0], ge_u};
            q_v_next   = {qv[QW-2:0], ge_v};
        end

        // Advance valid with the pipeline
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= vin;
            end
        end

        // Advance payload
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_u_reg[j] <= rem_u_next;
                rem_v_reg[j] <= rem_v_next;
                q_u_reg[j]   <= q_u_next;
                q_v_reg[j]   <= q_v_next;
                neg_u_reg[j] <= nu;
                neg_v_reg[j] <= nv;
                den_reg[j]   <= dn;
                side_reg[j]  <= sd;
            end
        end
    end

    // Restore the sign of the quotients
    assign out_valid = valid_reg[DS-1];
    assign out_side  = side_reg[DS-1];
    assign out_u = neg_u_reg[DS-1] ? -$signed({1'b0, q_u_reg[DS-1]})
                                   :  $signed({1'b0, q_u_reg[DS-1]});
    assign out_v = neg_v_reg[DS-1] ? -$signed({1'b0, q_v_reg[DS-1]})
                                   :  $signed({1'b0, q_v_reg[DS-1]});

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import lbm_pkg::*;

    localparam int  NCELL      = 1550;
    localparam int  DRAIN_WAIT = 60;
    localparam real TICK       = 6.0;

    typedef struct {
        logic signed [31:0] pre [9];
        logic               solid;
        logic [7:0]         blocked;
    } cell_t;

    typedef struct {
        logic signed [31:0] post [9];
        logic [7:0]         reflect;
        logic [RHOW-1:0]    density;
        status_t            status;
    } update_t;

    // Expected cell updates, oldest first, and the collision arithmetic
    class collision_scoreboard;
        update_t     pending_q[$];
        logic [RW-1:0] omega;
        int          errors;

        function new();
            omega  = RELAX_RESET;
            errors = 0;
        endfunction

        static function longint mag(longint a);
            return (a < 0) ? -a : a;
        endfunction

        // rounded fixed point product, saturating at the 64-bit limits
        static function longint fx_mul(longint a, longint b);
            logic [127:0] p;
            logic [63:0]  m;
            logic [63:0]  ma;
            logic [63:0]  mb;
            ma = (a < 0) ? 64'(-a) : 64'(a);
            mb = (b < 0) ? 64'(-b) : 64'(b);
            p  = {64'd0, ma} * {64'd0, mb};
            p  = p + (128'd1 << (FB - 1));
            if (p[127:FB+64] != 0)
                m = '1;
            else
                m = p[FB+63:FB];
            if (m > 64'h7FFF_FFFF_FFFF_FFFF)
                m = 64'h7FFF_FFFF_FFFF_FFFF;
            return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
        endfunction

        // momentum over density, truncated toward zero
        static function longint fx_div(longint num, longint den);
            longint q;
            q = (mag(num) << FB) / den;
            return (num < 0) ? -q : q;
        endfunction

        function void predict(cell_t c, output update_t r);
            longint f [9];
            longint rho, mx, my, u, v, usq, w, cu, poly, feq, post;
            int     dx [9];
            int     dy [9];
            bit     stable;
            dx = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
            dy = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
            foreach (r.post[k]) r.post[k] = 0;
            r.reflect = 0;
            r.density = 0;
            r.status  = STAT_OK;
            if (c.solid)
            begin
                r.status = STAT_SKIP;
                return;
            end
            rho = 0;
            for (int k = 0; k < 9; k++)
            begin
                f[k] = longint'(c.pre[k]);
                rho += f[k];
            end
            r.density = (rho < 0) ? 0 : ((rho > 64'h7FFF_FFFF) ? '1 : RHOW'(rho));
            mx = f[1] + f[5] + f[8] - f[3] - f[6] - f[7];
            my = f[2] + f[5] + f[6] - f[4] - f[7] - f[8];
            stable = rho >= Q_HALF && rho <= Q_RHO_MAX && mag(mx) <= rho && mag(my) <= rho;
            usq = 0;
            u = 0;
            v = 0;
            if (stable)
            begin
                u = fx_div(mx, rho);
                v = fx_div(my, rho);
                usq = fx_mul(u, u) + fx_mul(v, v);
                if (usq > SPEED2_MAX)
                    stable = 0;
            end
            if (!stable)
            begin
                r.status = STAT_UNSTABLE;
                return;
            end
            for (int k = 0; k < 9; k++)
            begin
                w = (k == 0) ? W_REST : ((k < 5) ? W_AXIS : W_DIAG);
                cu = dx[k] * u + dy[k] * v;
                poly = Q_ONE + 3 * cu + fx_mul(9 * Q_ONE / 2, fx_mul(cu, cu))
                       - fx_mul(3 * Q_ONE / 2, usq);
                feq = fx_mul(fx_mul(w, rho), poly);
                post = f[k] + fx_mul(longint'(omega), feq - f[k]);
                if (post > 64'sh7FFF_FFFF)
                    post = 64'sh7FFF_FFFF;
                if (post < -64'sh8000_0000)
                    post = -64'sh8000_0000;
                r.post[k] = post[31:0];
            end
            r.reflect = c.blocked;
        endfunction

        function void note_cell(cell_t c);
            update_t r;
            predict(c, r);
            pending_q.push_back(r);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        endtask

        task check_update(update_t got);
            update_t want;
            if (pending_q.size() == 0)
            begin
                report("unexpected transaction", 0, 0);
                return;
            end
            want = pending_q.pop_front();
            for (int k = 0; k < 9; k++)
                if (got.post[k] !== want.post[k])
                    report($sformatf("post_%0d", k), got.post[k], want.post[k]);
            if (got.reflect !== want.reflect)
                report("reflect_mask", got.reflect, want.reflect);
            if (got.density !== want.density)
                report("density", got.density, want.density);
            if (got.status !== want.status)
                report("status", got.status, want.status);
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [295:0]     s_tdata;    // pre_0..pre_8, blocked_dirs
    logic [0:0]       s_tuser;    // cell_solid
    logic             m_tvalid;
    logic             m_tready;
    logic [327:0]     m_tdata;    // post_0..post_8, reflect_mask, density, pad
    logic [1:0]       m_tuser;    // status
    logic             cfg_valid;
    logic             cfg_ready;
    logic [RW-1:0]    cfg_data;

    collision_scoreboard sb;
    bit  calm;
    bit  hold_req;

    lbm_d2q9_bgk_cell_update u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 0;
    end

    always
    begin
        #(TICK) clk = 1;
        #(TICK) clk = 0;
    end

    // Watch both channels and score every transaction
    always @(posedge clk)
    begin
        cell_t   c;
        update_t r;
        if (rst_n && s_tvalid && s_tready)
        begin
            for (int k = 0; k < 9; k++) c.pre[k] = s_tdata[32*k +: 32];
            c.blocked = s_tdata[295:288];
            c.solid   = s_tuser[0];
            sb.note_cell(c);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            for (int k = 0; k < 9; k++) r.post[k] = m_tdata[32*k +: 32];
            r.reflect = m_tdata[295:288];
            r.density = m_tdata[326:296];
            r.status  = status_t'(m_tuser);
            sb.check_update(r);
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        int n;
        m_tready = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 0;
                m_tready <= 0;
                repeat (300) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 16);
                m_tready <= 0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                n = $urandom_range(1, 24);
                m_tready <= 1;
                repeat (n) @(posedge clk);
            end
        end
    end

    task automatic write_omega(logic [RW-1:0] val);
        cfg_valid <= 1;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        sb.omega = val;
    endtask

    task automatic send_cell(cell_t c);
        int n;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 16);
            s_tvalid <= 0;
            repeat (n) @(posedge clk);
        end
        for (int k = 0; k < 9; k++) s_tdata[32*k +: 32] <= c.pre[k];
        s_tdata[295:288] <= c.blocked;
        s_tuser[0]       <= c.solid;
        s_tvalid         <= 1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic real frand(real lo, real hi);
        return lo + (hi - lo) * $urandom_range(0, 1000000) / 1.0e6;
    endfunction

    // Near-equilibrium cell with random density and velocity
    function automatic cell_t fluid_cell(real umax, real noise);
        cell_t c;
        real   rho, u, v, cu, w, fe;
        real   dx [9];
        real   dy [9];
        dx = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
        dy = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
        rho = frand(0.45, 1.55);
        u = frand(-umax, umax);
        v = frand(-umax, umax);
        for (int k = 0; k < 9; k++)
        begin
            w = (k == 0) ? 4.0 / 9 : ((k < 5) ? 1.0 / 9 : 1.0 / 36);
            cu = dx[k] * u + dy[k] * v;
            fe = w * rho * (1 + 3 * cu + 4.5 * cu * cu - 1.5 * (u * u + v * v));
            fe = fe + frand(-noise, noise);
            c.pre[k] = 32'(longint'(fe * 268435456.0));
        end
        c.solid   = 0;
        c.blocked = 8'($urandom);
        return c;
    endfunction

    function automatic cell_t random_cell();
        cell_t c;
        int    kind;
        kind = $urandom_range(0, 99);
        if (kind < 72)
            c = fluid_cell(0.2, 0.01);
        else
        begin
            for (int k = 0; k < 9; k++) c.pre[k] = $urandom;
            if (kind < 80)
                for (int k = 0; k < 9; k++) c.pre[k] = c.pre[k] >>> 4;
            c.blocked = 8'($urandom);
            c.solid   = 0;
        end
        if ($urandom_range(0, 9) == 0)
            c.solid = 1;
        return c;
    endfunction

    function automatic cell_t rest_cell(longint f0);
        cell_t c;
        foreach (c.pre[k]) c.pre[k] = 0;
        c.pre[0]  = 32'(f0);
        c.solid   = 0;
        c.blocked = 8'hFF;
        return c;
    endfunction

    task automatic send_directed();
        cell_t c;
        c = rest_cell(0);
        send_cell(c);
        c.solid = 1;
        foreach (c.pre[k]) c.pre[k] = 32'h7FFF_FFFF;
        send_cell(c);
        c = rest_cell(Q_HALF);
        send_cell(c);
        c = rest_cell(Q_HALF - 1);
        send_cell(c);
        c = rest_cell(Q_RHO_MAX);
        send_cell(c);
        c = rest_cell(Q_RHO_MAX + 1);
        send_cell(c);
        c = rest_cell(Q_ONE);
        c.blocked = 8'h00;
        send_cell(c);
        // extremes of every distribution
        foreach (c.pre[k]) c.pre[k] = 32'h7FFF_FFFF;
        send_cell(c);
        foreach (c.pre[k]) c.pre[k] = 32'h8000_0000;
        send_cell(c);
        // momentum within density, speed over the limit
        c = rest_cell(Q_HALF);
        c.pre[1] = 32'(Q_ONE);
        send_cell(c);
        // speed right at and just over the limit, along x
        c = rest_cell(Q_ONE - (Q_ONE / 5));
        c.pre[1] = 32'(Q_ONE / 5);
        send_cell(c);
        c = rest_cell(Q_ONE - (Q_ONE / 5) - 65536);
        c.pre[1] = 32'(Q_ONE / 5 + 65536);
        send_cell(c);
        // diagonal flow, negative momentum
        c = rest_cell(Q_ONE - Q_ONE / 10);
        c.pre[7] = 32'(Q_ONE / 10);
        send_cell(c);
        // large negative entries that still sum into range
        c = rest_cell(Q_ONE + 32'h1000_0000);
        c.pre[3] = 32'(-longint'(32'h1000_0000));
        send_cell(c);
        for (int i = 0; i < 8; i++)
        begin
            c = fluid_cell(0.15, 0.0);
            c.blocked = 8'(1 << i);
            send_cell(c);
        end
    endtask

    initial
    begin
        logic [RW-1:0] omegas [6];
        int            per_phase;
        sb = new();
        calm = 0;
        hold_req = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 0;
        cfg_data = '0;
        omegas = '{RELAX_RESET, '0, '1, RW'(Q_ONE), RW'($urandom), RW'(Q_ONE * 19 / 10)};
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // reset value first, directed cells before any write
        send_directed();
        drain();
        per_phase = (NCELL - 20) / 6;
        for (int p = 0; p < 6; p++)
        begin
            write_omega(omegas[p]);
            if (p == 5)
                calm = 1;
            for (int i = 0; i < per_phase; i++)
            begin
                if (p == 2 && i == 10)
                    hold_req = 1;
                if (p == 3 && i == per_phase / 2)
                    drain();
                send_cell(random_cell());
            end
            drain();
        end
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #(20ms);
        $display("== FAIL ==");
        $finish;
    end

endmodule
